// ----- src/tzt_pkg.sv -----
// ----------------------------------------------------------------------------
// tzt_pkg: shared types and constants of the temperature zone tracker
// Zone, event and alarm codes, register indexes, and the words that pass
// between the front, the queue and the back.
// ----------------------------------------------------------------------------
package tzt_pkg;

  localparam int TEMP_W   = 16;
  localparam int HYST_W   = 12;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int LEVEL_W  = 8;
  localparam int THR_W    = TEMP_W + 1;
  localparam int ZONE_COUNT  = 3;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ZONE_NORMAL  = 2'd0,
    ZONE_WARNING = 2'd1,
    ZONE_FAULT   = 2'd2
  } zone_t;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_FALL = 2'd1,
    EV_RISE = 2'd2
  } event_t;

  typedef enum logic [1:0] {
    ALARM_NORMAL  = 2'd1,
    ALARM_WARNING = 2'd2,
    ALARM_FAULT   = 2'd3
  } alarm_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WARNING_LEVEL = 2'd0,
    CFG_FAULT_LEVEL   = 2'd1,
    CFG_HYSTERESIS    = 2'd2
  } cfg_idx_t;

  localparam logic signed [TEMP_W-1:0] WARNING_RESET = 16'sd1200;
  localparam logic signed [TEMP_W-1:0] FAULT_RESET   = 16'sd1360;
  localparam logic [HYST_W-1:0]        HYST_RESET    = 12'd48;

  // Threshold registers as seen by the front and the back.
  typedef struct packed {
    logic signed [TEMP_W-1:0] warning_level;
    logic signed [TEMP_W-1:0] fault_level;
    logic [HYST_W-1:0]        hysteresis;
  } thr_t;

  // Classified sample: all compare results that the zone update needs.
  typedef struct packed {
    logic   below_drop0;  // below warning_level - hysteresis
    logic   below_drop1;  // below fault_level - hysteresis
    logic   above_warn;   // above warning_level
    logic   above_fault;  // above fault_level
    alarm_t alarm_class;
  } cls_t;

  typedef struct packed {
    zone_t                     zone;
    event_t                    event_code;
    logic signed [LEVEL_W-1:0] event_level;
    alarm_t                    alarm_class;
    logic                      temp_ok;
  } res_t;

  function automatic logic signed [THR_W-1:0] drop0(input thr_t thr);
    drop0 = $signed({thr.warning_level[TEMP_W-1], thr.warning_level})
          - $signed({{(THR_W-HYST_W){1'b0}}, thr.hysteresis});
  endfunction

  function automatic logic signed [THR_W-1:0] drop1(input thr_t thr);
    drop1 = $signed({thr.fault_level[TEMP_W-1], thr.fault_level})
          - $signed({{(THR_W-HYST_W){1'b0}}, thr.hysteresis});
  endfunction

endpackage

// ----- src/temperature_zone_tracker.sv -----
// ----------------------------------------------------------------------------
// temperature_zone_tracker: three-zone temperature tracker with hysteresis
// Classifies averaged temperature samples into normal, warning and fault
// zones, reports zone changes with the crossed threshold, and gives a plain
// alarm class and an ok flag.
//
//   channel  ports                                   handshake
//   -------  --------------------------------------  ------------------------
//   input    in_temperature                          in_push / in_full
//   result   out_zone, out_event_code,               out_pop / out_empty
//            out_event_level, out_alarm_class,
//            out_temp_ok
//   config   cfg_index, cfg_data                     cfg_we, no wait
//
// One word per cycle is sustained while the consumer keeps popping. A sample
// is written from push into the classified-word queue, then goes through the
// zone update into the result register; the zone register closes its loop in
// the update stage. Reset sets the thresholds to their defaults and leaves
// the zone unplaced. A stalled consumer fills the result register and then
// the two-word queue before in_full rises.
// ----------------------------------------------------------------------------
module temperature_zone_tracker #(
  parameter int FRACTION_BITS = 4
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_push,
  output logic                                     in_full,
  input  logic signed [tzt_pkg::TEMP_W-1:0]        in_temperature,
  output logic                                     out_empty,
  input  logic                                     out_pop,
  output logic [1:0]                               out_zone,
  output logic [1:0]                               out_event_code,
  output logic signed [tzt_pkg::LEVEL_W-1:0]       out_event_level,
  output logic [1:0]                               out_alarm_class,
  output logic                                     out_temp_ok,
  input  logic                                     cfg_we,
  input  logic [tzt_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [tzt_pkg::CFG_W-1:0]                cfg_data
);

  tzt_pkg::thr_t thr_r, thr_nxt;
  tzt_pkg::cls_t front_word, back_word;
  tzt_pkg::res_t res;
  logic          q_push, q_full, q_valid, q_pop;

  always_comb begin
    thr_nxt = thr_r;
    if (cfg_we) begin
      unique case (cfg_index)
        tzt_pkg::CFG_WARNING_LEVEL: thr_nxt.warning_level = $signed(cfg_data);
        tzt_pkg::CFG_FAULT_LEVEL:   thr_nxt.fault_level   = $signed(cfg_data);
        tzt_pkg::CFG_HYSTERESIS:    thr_nxt.hysteresis    = cfg_data[tzt_pkg::HYST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.warning_level <= tzt_pkg::WARNING_RESET;
      thr_r.fault_level   <= tzt_pkg::FAULT_RESET;
      thr_r.hysteresis    <= tzt_pkg::HYST_RESET;
    end else begin
      thr_r <= thr_nxt;
    end
  end

  tzt_front u_front (
    .in_push        (in_push),
    .in_temperature (in_temperature),
    .thr            (thr_r),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_word         (front_word)
  );

  tzt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (front_word),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_word  (back_word)
  );

  tzt_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .thr       (thr_r),
    .q_valid   (q_valid),
    .q_word    (back_word),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .res       (res)
  );

  assign in_full         = q_full;
  assign out_zone        = res.zone;
  assign out_event_code  = res.event_code;
  assign out_event_level = res.event_level;
  assign out_alarm_class = res.alarm_class;
  assign out_temp_ok     = res.temp_ok;

  // A word waiting in the queue with room in the result register must show.
  a_back_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && (out_empty || out_pop)) |=> !out_empty)
    else $error("queued word did not reach the result register");

  // A rise always ends above the normal zone, a fall always below fault.
  a_rise_zone: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_event_code == tzt_pkg::EV_RISE) |-> out_zone != tzt_pkg::ZONE_NORMAL)
    else $error("rise event reported in the normal zone");

  a_fall_zone: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_event_code == tzt_pkg::EV_FALL) |-> out_zone != tzt_pkg::ZONE_FAULT)
    else $error("fall event reported in the fault zone");

  // No event, no level.
  a_quiet_level: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_event_code == tzt_pkg::EV_NONE) |-> out_event_level == '0)
    else $error("event level set without an event");

endmodule

// ----- src/tzt_front.sv -----
// ----------------------------------------------------------------------------
// tzt_front: sample classifier
// Compares each accepted sample against the zone thresholds and the alarm
// levels, and hands the classified word to the queue.
// ----------------------------------------------------------------------------
module tzt_front (
  input  logic                                in_push,
  input  logic signed [tzt_pkg::TEMP_W-1:0]   in_temperature,
  input  tzt_pkg::thr_t                       thr,
  input  logic                                q_full,
  output logic                                q_push,
  output tzt_pkg::cls_t                       q_word
);

  logic signed [tzt_pkg::THR_W-1:0] temp_x;
  logic signed [tzt_pkg::THR_W-1:0] warn_x;
  logic signed [tzt_pkg::THR_W-1:0] fault_x;

  assign temp_x  = $signed({in_temperature[tzt_pkg::TEMP_W-1], in_temperature});
  assign warn_x  = $signed({thr.warning_level[tzt_pkg::TEMP_W-1], thr.warning_level});
  assign fault_x = $signed({thr.fault_level[tzt_pkg::TEMP_W-1], thr.fault_level});

  assign q_push = in_push & ~q_full;

  // The fault zone needs no compare of its own: a first sample that is not
  // below either drop level lands there anyway.
  always_comb begin
    q_word.below_drop0 = temp_x < tzt_pkg::drop0(thr);
    q_word.below_drop1 = temp_x < tzt_pkg::drop1(thr);
    q_word.above_warn  = temp_x > warn_x;
    q_word.above_fault = temp_x > fault_x;
    if (!q_word.above_warn) begin
      q_word.alarm_class = tzt_pkg::ALARM_NORMAL;
    end else if (q_word.above_fault) begin
      q_word.alarm_class = tzt_pkg::ALARM_FAULT;
    end else begin
      q_word.alarm_class = tzt_pkg::ALARM_WARNING;
    end
  end

endmodule

// ----- src/tzt_queue.sv -----
// ----------------------------------------------------------------------------
// tzt_queue: short queue of classified words
// Decouples the classifier from the zone update so that each side can stall
// on its own.
// ----------------------------------------------------------------------------
module tzt_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tzt_pkg::cls_t push_word,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output tzt_pkg::cls_t pop_word
);

  localparam int PTR_W = $clog2(tzt_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(tzt_pkg::QUEUE_DEPTH + 1);

  tzt_pkg::cls_t    mem_r [tzt_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = count_r == CNT_W'(tzt_pkg::QUEUE_DEPTH);
  assign valid    = count_r != '0;
  assign pop_word = mem_r[rd_ptr_r];
  assign do_push  = push & ~full;
  assign do_pop   = pop & valid;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(tzt_pkg::QUEUE_DEPTH - 1)) begin
      ptr_inc = '0;
    end else begin
      ptr_inc = p + PTR_W'(1);
    end
  endfunction

  always_comb begin
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

// ----- src/tzt_back.sv -----
// ----------------------------------------------------------------------------
// tzt_back: zone update and result register
// Moves the hysteresis zone by at most one step per word, reports the
// crossed threshold in whole degrees, and holds the result for the consumer.
// ----------------------------------------------------------------------------
module tzt_back #(
  parameter int FRACTION_BITS = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  tzt_pkg::thr_t thr,
  input  logic          q_valid,
  input  tzt_pkg::cls_t q_word,
  output logic          q_pop,
  input  logic          out_pop,
  output logic          out_empty,
  output tzt_pkg::res_t res
);

  localparam int THR_W = tzt_pkg::THR_W;
  localparam logic signed [THR_W-1:0] SAT_HI = THR_W'(127);
  localparam logic signed [THR_W-1:0] SAT_LO = -THR_W'(128);

  tzt_pkg::zone_t zone_r, zone_nxt;
  logic           known_r, known_nxt;
  logic           out_valid_r, out_valid_nxt;
  tzt_pkg::res_t  res_r, res_nxt;
  tzt_pkg::event_t ev;

  logic signed [THR_W-1:0] level_val;
  logic signed [THR_W-1:0] level_deg;
  logic signed [tzt_pkg::LEVEL_W-1:0] level_sat;

  assign q_pop     = q_valid & (~out_valid_r | out_pop);
  assign out_empty = ~out_valid_r;
  assign res       = res_r;

  // Arithmetic shift floors toward minus infinity.
  assign level_deg = level_val >>> FRACTION_BITS;

  always_comb begin
    if (level_deg > SAT_HI) begin
      level_sat = tzt_pkg::LEVEL_W'(127);
    end else if (level_deg < SAT_LO) begin
      level_sat = -tzt_pkg::LEVEL_W'(128);
    end else begin
      level_sat = level_deg[tzt_pkg::LEVEL_W-1:0];
    end
  end

  always_comb begin
    zone_nxt  = zone_r;
    known_nxt = known_r;
    ev        = tzt_pkg::EV_NONE;
    level_val = '0;
    if (!known_r) begin
      known_nxt = 1'b1;
      if (q_word.below_drop0) begin
        zone_nxt = tzt_pkg::ZONE_NORMAL;
      end else if (q_word.below_drop1) begin
        zone_nxt = tzt_pkg::ZONE_WARNING;
      end else begin
        zone_nxt = tzt_pkg::ZONE_FAULT;
      end
    end else begin
      // A fall is tested before a rise.
      unique case (zone_r)
        tzt_pkg::ZONE_NORMAL: begin
          if (q_word.above_warn) begin
            zone_nxt  = tzt_pkg::ZONE_WARNING;
            ev        = tzt_pkg::EV_RISE;
            level_val = $signed({thr.warning_level[tzt_pkg::TEMP_W-1], thr.warning_level});
          end
        end
        tzt_pkg::ZONE_WARNING: begin
          if (q_word.below_drop0) begin
            zone_nxt  = tzt_pkg::ZONE_NORMAL;
            ev        = tzt_pkg::EV_FALL;
            level_val = tzt_pkg::drop0(thr);
          end else if (q_word.above_fault) begin
            zone_nxt  = tzt_pkg::ZONE_FAULT;
            ev        = tzt_pkg::EV_RISE;
            level_val = $signed({thr.fault_level[tzt_pkg::TEMP_W-1], thr.fault_level});
          end
        end
        tzt_pkg::ZONE_FAULT: begin
          if (q_word.below_drop1) begin
            zone_nxt  = tzt_pkg::ZONE_WARNING;
            ev        = tzt_pkg::EV_FALL;
            level_val = tzt_pkg::drop1(thr);
          end
        end
        default: begin
          zone_nxt = tzt_pkg::ZONE_NORMAL;
        end
      endcase
    end
  end

  always_comb begin
    res_nxt.zone        = zone_nxt;
    res_nxt.event_code  = ev;
    res_nxt.event_level = (ev == tzt_pkg::EV_NONE) ? '0 : level_sat;
    res_nxt.alarm_class = q_word.alarm_class;
    res_nxt.temp_ok     = q_word.alarm_class != tzt_pkg::ALARM_FAULT;
  end

  assign out_valid_nxt = q_pop | (out_valid_r & ~out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r      <= tzt_pkg::ZONE_NORMAL;
      known_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        zone_r  <= zone_nxt;
        known_r <= known_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ----- bench/temperature_zone_tracker_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temperature_zone_tracker_tb: self-checking bench for the zone tracker
// Feeds temperature samples through the push/full side and checks every
// result word against a cycle-free predictor of the zone, event, alarm class
// and ok flag. Threshold settings change between phases, among them the
// 16-bit extremes, inverted warning/fault levels and saturating event levels.
// Both sides idle at random, and the result side is held off long enough
// to back the block up.
// ----------------------------------------------------------------------------
module temperature_zone_tracker_tb;

  localparam int FRAC_BITS   = 4;
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 60;
  localparam tzt_pkg::cfg_idx_t CFG_UNUSED = tzt_pkg::cfg_idx_t'(2'd3);

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_push = 1'b0;
  logic                              in_full;
  logic signed [tzt_pkg::TEMP_W-1:0] in_temperature = '0;
  logic                              out_empty;
  logic                              out_pop = 1'b0;
  logic [1:0]                        out_zone;
  logic [1:0]                        out_event_code;
  logic signed [tzt_pkg::LEVEL_W-1:0] out_event_level;
  logic [1:0]                        out_alarm_class;
  logic                              out_temp_ok;
  logic                              cfg_we = 1'b0;
  logic [tzt_pkg::CFG_IDX_W-1:0]     cfg_index = tzt_pkg::CFG_WARNING_LEVEL;
  logic [tzt_pkg::CFG_W-1:0]         cfg_data = '0;

  temperature_zone_tracker #(
    .FRACTION_BITS(FRAC_BITS)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_temperature (in_temperature),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_zone       (out_zone),
    .out_event_code (out_event_code),
    .out_event_level(out_event_level),
    .out_alarm_class(out_alarm_class),
    .out_temp_ok    (out_temp_ok),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state and its copy of the threshold registers.
  logic signed [tzt_pkg::TEMP_W-1:0] warn_lvl = tzt_pkg::WARNING_RESET;
  logic signed [tzt_pkg::TEMP_W-1:0] fault_lvl = tzt_pkg::FAULT_RESET;
  logic [tzt_pkg::HYST_W-1:0]        hyst = tzt_pkg::HYST_RESET;
  tzt_pkg::zone_t                    zone_now = tzt_pkg::ZONE_NORMAL;
  bit                                zone_placed = 1'b0;

  logic signed [tzt_pkg::TEMP_W-1:0] samples_waiting[$];
  tzt_pkg::res_t                     zone_results[$];

  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int fail_count = 0;
  int words_in = 0;
  int words_out = 0;
  int rises = 0;
  int falls = 0;
  int settings_used = 1;

  function automatic logic signed [tzt_pkg::LEVEL_W-1:0] whole_degrees(input int v);
    int d;
    d = v >>> FRAC_BITS;  // floor toward minus infinity
    if (d > 127) d = 127;
    if (d < -128) d = -128;
    return d[tzt_pkg::LEVEL_W-1:0];
  endfunction

  function automatic logic signed [tzt_pkg::TEMP_W-1:0] clamp16(input int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[tzt_pkg::TEMP_W-1:0];
  endfunction

  // Advances the predicted zone by one sample and returns the expected word.
  function automatic tzt_pkg::res_t track_sample(input logic signed [tzt_pkg::TEMP_W-1:0] t);
    int            temp;
    int            w;
    int            f;
    int            d0;
    int            d1;
    tzt_pkg::res_t r;
    temp = t;
    w = warn_lvl;
    f = fault_lvl;
    d0 = w - int'(hyst);
    d1 = f - int'(hyst);
    r = '0;
    if (temp <= w) r.alarm_class = tzt_pkg::ALARM_NORMAL;
    else if (temp <= f) r.alarm_class = tzt_pkg::ALARM_WARNING;
    else r.alarm_class = tzt_pkg::ALARM_FAULT;
    r.temp_ok = (r.alarm_class != tzt_pkg::ALARM_FAULT);
    r.event_code = tzt_pkg::EV_NONE;
    if (!zone_placed) begin
      // Anything not below the fault drop level is placed in fault.
      if (temp < d0) zone_now = tzt_pkg::ZONE_NORMAL;
      else if (temp < d1) zone_now = tzt_pkg::ZONE_WARNING;
      else zone_now = tzt_pkg::ZONE_FAULT;
      zone_placed = 1'b1;
    end else begin
      case (zone_now)
        tzt_pkg::ZONE_FAULT: begin
          if (temp < d1) begin
            zone_now = tzt_pkg::ZONE_WARNING;
            r.event_code = tzt_pkg::EV_FALL;
            r.event_level = whole_degrees(d1);
          end
        end
        tzt_pkg::ZONE_WARNING: begin
          if (temp < d0) begin
            zone_now = tzt_pkg::ZONE_NORMAL;
            r.event_code = tzt_pkg::EV_FALL;
            r.event_level = whole_degrees(d0);
          end else if (temp > f) begin
            zone_now = tzt_pkg::ZONE_FAULT;
            r.event_code = tzt_pkg::EV_RISE;
            r.event_level = whole_degrees(f);
          end
        end
        default: begin
          if (temp > w) begin
            zone_now = tzt_pkg::ZONE_WARNING;
            r.event_code = tzt_pkg::EV_RISE;
            r.event_level = whole_degrees(w);
          end
        end
      endcase
    end
    r.zone = zone_now;
    return r;
  endfunction

  // Sample source: drives the oldest pending sample at the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (samples_waiting.size() != 0 &&
                 $urandom_range(99) >= send_idle_pct) begin
      in_push <= 1'b1;
      in_temperature <= samples_waiting[0];
    end else begin
      in_push <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) begin
      zone_results.push_back(track_sample(samples_waiting.pop_front()));
      words_in++;
    end
  end

  // Result side: random stalls, plus long holds on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else if (holds_done < holds_asked) begin
      holds_done++;
      hold_left = LONG_HOLD - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  always @(posedge clk) begin
    tzt_pkg::res_t want;
    if (rst_n && out_pop && !out_empty) begin
      words_out++;
      if (zone_results.size() == 0) begin
        $error("result word with no sample pending: zone %0d event %0d",
               out_zone, out_event_code);
        fail_count++;
      end else begin
        want = zone_results.pop_front();
        if (want.event_code == tzt_pkg::EV_RISE) rises++;
        if (want.event_code == tzt_pkg::EV_FALL) falls++;
        if (out_zone !== want.zone) begin
          $error("zone: expected %0d, got %0d", want.zone, out_zone);
          fail_count++;
        end
        if (out_event_code !== want.event_code) begin
          $error("event_code: expected %0d, got %0d", want.event_code, out_event_code);
          fail_count++;
        end
        if (out_event_level !== want.event_level) begin
          $error("event_level: expected %0d, got %0d", want.event_level, out_event_level);
          fail_count++;
        end
        if (out_alarm_class !== want.alarm_class) begin
          $error("alarm_class: expected %0d, got %0d", want.alarm_class, out_alarm_class);
          fail_count++;
        end
        if (out_temp_ok !== want.temp_ok) begin
          $error("temp_ok: expected %0d, got %0d", want.temp_ok, out_temp_ok);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too long without any word moving on either side.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(input tzt_pkg::cfg_idx_t idx,
                           input logic [tzt_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tzt_pkg::CFG_WARNING_LEVEL: warn_lvl = data;
      tzt_pkg::CFG_FAULT_LEVEL:   fault_lvl = data;
      tzt_pkg::CFG_HYSTERESIS:    hyst = data[tzt_pkg::HYST_W-1:0];
      default: ;
    endcase
  endtask

  // Hysteresis writes carry junk in the upper bits, which must be dropped.
  task automatic set_thresholds(input int w, input int f, input int h);
    logic [3:0] junk;
    junk = 4'($urandom_range(15));
    write_reg(tzt_pkg::CFG_WARNING_LEVEL, clamp16(w));
    write_reg(tzt_pkg::CFG_FAULT_LEVEL, clamp16(f));
    write_reg(tzt_pkg::CFG_HYSTERESIS, {junk, h[tzt_pkg::HYST_W-1:0]});
    settings_used++;
  endtask

  task automatic wait_drained();
    while (samples_waiting.size() != 0 || zone_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [tzt_pkg::TEMP_W-1:0] random_sample();
    int w;
    int f;
    int h;
    int lo;
    int hi;
    int pick;
    w = warn_lvl;
    f = fault_lvl;
    h = hyst;
    lo = ((w < f) ? w : f) - h - 150;
    hi = ((w > f) ? w : f) + 150;
    pick = $urandom_range(99);
    if (pick < 45) begin
      case ($urandom_range(3))
        0: return clamp16(w + $urandom_range(8) - 4);
        1: return clamp16(f + $urandom_range(8) - 4);
        2: return clamp16(w - h + $urandom_range(8) - 4);
        default: return clamp16(f - h + $urandom_range(8) - 4);
      endcase
    end else if (pick < 75) begin
      return clamp16(lo + int'($urandom_range(hi - lo)));
    end else if (pick < 92) begin
      return tzt_pkg::TEMP_W'($urandom);
    end else begin
      case ($urandom_range(3))
        0: return 16'sh7fff;
        1: return 16'sh8000;
        2: return 16'sh0000;
        default: return 16'shffff;
      endcase
    end
  endfunction

  // Mostly sweeps across all thresholds in both directions, with noise mixed in.
  task automatic queue_random(input int count);
    int left;
    int lo;
    int hi;
    int steps;
    int k;
    bit up;
    left = count;
    while (left > 0) begin
      if ($urandom_range(9) < 3) begin
        lo = ((warn_lvl < fault_lvl) ? int'(warn_lvl) : int'(fault_lvl)) - int'(hyst) - 40;
        hi = ((warn_lvl > fault_lvl) ? int'(warn_lvl) : int'(fault_lvl)) + 40;
        steps = $urandom_range(30, 6);
        if (steps > left) steps = left;
        if (steps < 2) steps = 2;
        up = $urandom_range(1);
        for (k = 0; k < steps; k++) begin
          if (up) samples_waiting.push_back(clamp16(lo + (hi - lo) * k / (steps - 1)));
          else samples_waiting.push_back(clamp16(hi - (hi - lo) * k / (steps - 1)));
        end
        left -= steps;
      end else begin
        samples_waiting.push_back(random_sample());
        left--;
      end
    end
  endtask

  task automatic run_phase(input int count, input int send_pct, input int pop_pct,
                           input bit long_hold);
    send_idle_pct = send_pct;
    pop_stall_pct = pop_pct;
    queue_random(count);
    if (long_hold) holds_asked++;
    wait_drained();
  endtask

  task automatic random_thresholds();
    int w;
    w = int'($urandom_range(5000)) - 1500;
    if ($urandom_range(3) == 0) set_thresholds(w, w - int'($urandom_range(400)),
                                               $urandom_range(4095));
    else set_thresholds(w, w + int'($urandom_range(600)), $urandom_range(200));
  endtask

  initial begin
    logic signed [tzt_pkg::TEMP_W-1:0] opening[$];
    opening = '{16'sd1300, 16'sd1360, 16'sd1361, 16'sh7fff, 16'sd1312, 16'sd1311,
                16'sd1152, 16'sd1151, 16'sd1200, 16'sd1201, 16'sh8000, 16'sh8000,
                16'sh7fff, 16'sh7fff, 16'sh8000, 16'sd0, 16'sd0, 16'shffff,
                16'sh5555, 16'shaaaa, 16'sd3200, 16'sd1152};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset thresholds: first placement lands in warning, then every move,
    // equality on both strict compares, and the 16-bit extremes.
    foreach (opening[j]) samples_waiting.push_back(opening[j]);
    wait_drained();
    run_phase(260, 0, 0, 1'b1);

    // Warning above fault with full hysteresis; both levels saturate.
    write_reg(CFG_UNUSED, 16'($urandom));
    set_thresholds(32767, -32768, 4095);
    run_phase(200, 47, 0, 1'b0);
    set_thresholds(-32768, 32767, 0);
    run_phase(200, 0, 47, 1'b0);
    // Small negative levels check the floor toward minus infinity.
    set_thresholds(-8, -3, 1);
    run_phase(200, 21, 21, 1'b0);
    set_thresholds(2040, 2100, 4095);
    run_phase(200, 0, 0, 1'b1);
    random_thresholds();
    run_phase(200, 47, 0, 1'b0);
    random_thresholds();
    run_phase(200, 0, 47, 1'b0);
    random_thresholds();
    run_phase(200, 21, 21, 1'b0);

    if (zone_results.size() != 0) begin
      $error("%0d expected result words never arrived", zone_results.size());
      fail_count++;
    end
    $display("Run covered %0d samples under %0d threshold settings, %0d long output holds.",
             words_in, settings_used, holds_done);
    $display("Checked %0d result words, including %0d zone rises and %0d zone falls.",
             words_out, rises, falls);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
